// File: rtl/raster_video_attribute_fetch_unit_defines.svh
// Assertion macros used by the video fetch RTL.
`ifndef RASTER_VIDEO_ATTRIBUTE_FETCH_UNIT_DEFINES_SVH
`define RASTER_VIDEO_ATTRIBUTE_FETCH_UNIT_DEFINES_SVH

// Same-cycle implication.
`define RVAF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RVAF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rvaf_pkg.sv
package rvaf_pkg;

    localparam int VRAM_DEPTH   = 8192;
    localparam int VRAM_AW      = $clog2(VRAM_DEPTH);
    localparam int DISPLAY_COLS = 32;
    localparam int DISPLAY_ROWS = 192;
    localparam int ATTR_OFFSET  = 6144;
    localparam int BEAM_W       = 9;
    localparam int FLASH_W      = 20;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 20;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_CYCLES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LINES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IRQ_LINE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IRQ_FIRST     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IRQ_LAST      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DISP_CYCLE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DISP_LINE     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_PERIOD  = 3'd7;

    localparam logic [BEAM_W-1:0]  RST_LINE_CYCLES  = 9'd56;
    localparam logic [BEAM_W-1:0]  RST_FRAME_LINES  = 9'd312;
    localparam logic [BEAM_W-1:0]  RST_IRQ_LINE     = 9'd0;
    localparam logic [BEAM_W-1:0]  RST_IRQ_FIRST    = 9'd0;
    localparam logic [BEAM_W-1:0]  RST_IRQ_LAST     = 9'd8;
    localparam logic [BEAM_W-1:0]  RST_DISP_CYCLE   = 9'd8;
    localparam logic [BEAM_W-1:0]  RST_DISP_LINE    = 9'd64;
    localparam logic [FLASH_W-1:0] RST_FLASH_PERIOD = 20'd279552;

    localparam int ATTR_FLASH_BIT  = 7;
    localparam int ATTR_BRIGHT_BIT = 6;

    localparam logic req_tick  = 1'b0;
    localparam logic req_write = 1'b1;

    typedef struct packed {
        logic [BEAM_W-1:0]  line_cycles;
        logic [BEAM_W-1:0]  frame_lines;
        logic [BEAM_W-1:0]  irq_line;
        logic [BEAM_W-1:0]  irq_first_cycle;
        logic [BEAM_W-1:0]  irq_last_cycle;
        logic [BEAM_W-1:0]  display_first_cycle;
        logic [BEAM_W-1:0]  display_first_line;
        logic [FLASH_W-1:0] flash_period;
    } cfg_t;

    // per-request result fields known before the memory read
    typedef struct packed {
        logic       irq_level;
        logic       pixel_valid;
        logic [7:0] row;
        logic [4:0] col;
        logic       flash_phase;
        logic       line_end;
        logic       frame_end;
    } fetch_t;

endpackage

// File: rtl/raster_video_attribute_fetch_unit.sv
// Raster video generator with a 8 KiB video memory and attribute fetch.
// Request channel (in_valid/in_ready): req_type selects a beam tick or a
// video memory byte write (write_addr, write_data). Every request gives
// exactly one result on the out channel (out_valid/out_ready).
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready
// and must only be used while no request is in flight.
// Path: an accepted request passes the memory read stage, then the output
// register, which raises out_valid.
// Throughput: one request per cycle while out_ready stays high; the video
// memory has one write port and two read ports so a tick reads its bitmap
// and attribute bytes in the same cycle.
// Reset: configuration returns to its defaults, beam, interrupt and flash
// state clear, and the video memory is swept to zero one byte per cycle,
// while in_ready stays low.
// Stall: with out_ready low the output and memory read stage hold; in_ready
// drops once the read stage is occupied, so nothing is lost.
`include "raster_video_attribute_fetch_unit_defines.svh"

module raster_video_attribute_fetch_unit
    import rvaf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  req_type,
    input  logic [VRAM_AW-1:0]    write_addr,
    input  logic [7:0]            write_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  irq_level,
    output logic                  pixel_valid,
    output logic [7:0]            pixel_row,
    output logic [4:0]            byte_column,
    output logic [7:0]            bitmap_byte,
    output logic [3:0]            ink_code,
    output logic [3:0]            paper_code,
    output logic                  line_end,
    output logic                  frame_end
);

    cfg_t               cfg_reg;
    cfg_t               cfg_next;
    fetch_t             info;
    fetch_t             s1_reg;
    fetch_t             s1_next;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               out_valid_reg;
    logic               irq_now;
    logic [VRAM_AW-1:0] pixel_addr;
    logic [VRAM_AW-1:0] attr_addr;
    logic [7:0]         bits_rd;
    logic [7:0]         attr_rd;
    logic               vram_ready;
    logic               adv;
    logic               in_acc;
    logic               tick;
    logic               wr;
    logic               swap;
    logic [3:0]         ink_dec;
    logic [3:0]         paper_dec;

    logic               irq_level_reg;
    logic               pixel_valid_reg;
    logic [7:0]         pixel_row_reg;
    logic [4:0]         byte_column_reg;
    logic [7:0]         bitmap_byte_reg;
    logic [3:0]         ink_code_reg;
    logic [3:0]         paper_code_reg;
    logic               line_end_reg;
    logic               frame_end_reg;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_LINE_CYCLES:  cfg_next.line_cycles         = cfg_data[BEAM_W-1:0];
                REG_FRAME_LINES:  cfg_next.frame_lines         = cfg_data[BEAM_W-1:0];
                REG_IRQ_LINE:     cfg_next.irq_line            = cfg_data[BEAM_W-1:0];
                REG_IRQ_FIRST:    cfg_next.irq_first_cycle     = cfg_data[BEAM_W-1:0];
                REG_IRQ_LAST:     cfg_next.irq_last_cycle      = cfg_data[BEAM_W-1:0];
                REG_DISP_CYCLE:   cfg_next.display_first_cycle = cfg_data[BEAM_W-1:0];
                REG_DISP_LINE:    cfg_next.display_first_line  = cfg_data[BEAM_W-1:0];
                REG_FLASH_PERIOD: cfg_next.flash_period        = cfg_data[FLASH_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_cycles         <= RST_LINE_CYCLES;
            cfg_reg.frame_lines         <= RST_FRAME_LINES;
            cfg_reg.irq_line            <= RST_IRQ_LINE;
            cfg_reg.irq_first_cycle     <= RST_IRQ_FIRST;
            cfg_reg.irq_last_cycle      <= RST_IRQ_LAST;
            cfg_reg.display_first_cycle <= RST_DISP_CYCLE;
            cfg_reg.display_first_line  <= RST_DISP_LINE;
            cfg_reg.flash_period        <= RST_FLASH_PERIOD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = vram_ready && (!s1_valid_reg || adv);
    assign in_acc   = in_valid && in_ready;
    assign tick     = in_acc && req_type == req_tick;
    assign wr       = in_acc && req_type == req_write;

    rvaf_beam u_beam
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .tick       (tick),
        .info       (info),
        .irq_now    (irq_now),
        .pixel_addr (pixel_addr),
        .attr_addr  (attr_addr)
    );

    rvaf_vram u_vram
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr),
        .wr_addr   (write_addr),
        .wr_data   (write_data),
        .rd_en     (tick && info.pixel_valid),
        .rd_addr_a (pixel_addr),
        .rd_addr_b (attr_addr),
        .rd_data_a (bits_rd),
        .rd_data_b (attr_rd),
        .ready     (vram_ready)
    );

    // read stage
    always_comb
    begin
        s1_valid_next = in_acc || (s1_valid_reg && !adv);
        s1_next       = s1_reg;
        if (tick)
        begin
            s1_next = info;
        end
        else if (wr)
        begin
            s1_next           = '0;
            s1_next.irq_level = irq_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    // attribute decode
    always_comb
    begin
        ink_dec   = {attr_rd[ATTR_BRIGHT_BIT], attr_rd[2:0]};
        paper_dec = {attr_rd[ATTR_BRIGHT_BIT], attr_rd[5:3]};
        swap      = attr_rd[ATTR_FLASH_BIT] && s1_reg.flash_phase;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            irq_level_reg   <= s1_reg.irq_level;
            pixel_valid_reg <= s1_reg.pixel_valid;
            pixel_row_reg   <= s1_reg.row;
            byte_column_reg <= s1_reg.col;
            line_end_reg    <= s1_reg.line_end;
            frame_end_reg   <= s1_reg.frame_end;
            if (s1_reg.pixel_valid)
            begin
                bitmap_byte_reg <= bits_rd;
                ink_code_reg    <= swap ? paper_dec : ink_dec;
                paper_code_reg  <= swap ? ink_dec : paper_dec;
            end
            else
            begin
                bitmap_byte_reg <= 8'd0;
                ink_code_reg    <= 4'd0;
                paper_code_reg  <= 4'd0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign irq_level   = irq_level_reg;
    assign pixel_valid = pixel_valid_reg;
    assign pixel_row   = pixel_row_reg;
    assign byte_column = byte_column_reg;
    assign bitmap_byte = bitmap_byte_reg;
    assign ink_code    = ink_code_reg;
    assign paper_code  = paper_code_reg;
    assign line_end    = line_end_reg;
    assign frame_end   = frame_end_reg;

    `RVAF_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !adv, s1_valid_reg, "read stage dropped a request")
    `RVAF_ASSERT_NOW(a_acc_after_clear, in_valid && in_ready, vram_ready, "request during memory clear")
    `RVAF_ASSERT_NOW(a_row_range, out_valid_reg && pixel_valid_reg, pixel_row_reg < 8'(DISPLAY_ROWS), "display row out of range")
    `RVAF_ASSERT_NOW(a_frame_line, out_valid_reg && frame_end_reg, line_end_reg, "frame end without line end")

endmodule

// File: rtl/rvaf_vram.sv
module rvaf_vram
    import rvaf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [VRAM_AW-1:0] wr_addr,
    input  logic [7:0]         wr_data,
    input  logic               rd_en,
    input  logic [VRAM_AW-1:0] rd_addr_a,
    input  logic [VRAM_AW-1:0] rd_addr_b,
    output logic [7:0]         rd_data_a,
    output logic [7:0]         rd_data_b,
    output logic               ready
);

    logic [7:0]         mem [VRAM_DEPTH];
    logic [VRAM_AW-1:0] clr_addr_reg;
    logic [VRAM_AW-1:0] clr_addr_next;
    logic               clr_done_reg;
    logic               clr_done_next;
    logic [7:0]         rd_a_reg;
    logic [7:0]         rd_b_reg;
    logic               mem_we;
    logic [VRAM_AW-1:0] mem_wa;
    logic [7:0]         mem_wd;

    // zero sweep after reset
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_done_next = clr_done_reg;
        if (!clr_done_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (&clr_addr_reg)
            begin
                clr_done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_done_reg <= 1'b0;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_done_reg <= clr_done_next;
        end
    end

    assign mem_we = !clr_done_reg || wr_en;
    assign mem_wa = clr_done_reg ? wr_addr : clr_addr_reg;
    assign mem_wd = clr_done_reg ? wr_data : 8'd0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;
    assign ready     = clr_done_reg;

endmodule

// File: rtl/rvaf_beam.sv
module rvaf_beam
    import rvaf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               tick,
    output fetch_t             info,
    output logic               irq_now,
    output logic [VRAM_AW-1:0] pixel_addr,
    output logic [VRAM_AW-1:0] attr_addr
);

    logic [BEAM_W-1:0]  cycle_reg;
    logic [BEAM_W-1:0]  cycle_next;
    logic [BEAM_W-1:0]  line_reg;
    logic [BEAM_W-1:0]  line_next;
    logic               irq_reg;
    logic               irq_next;
    logic [FLASH_W-1:0] flash_cnt_reg;
    logic [FLASH_W-1:0] flash_cnt_next;
    logic               flash_reg;
    logic               flash_next;
    logic [BEAM_W-1:0]  col_off;
    logic [BEAM_W-1:0]  row_off;
    logic [BEAM_W-1:0]  cycle_inc;
    logic [BEAM_W-1:0]  line_inc;
    logic [FLASH_W:0]   flash_inc;
    logic               in_window;
    logic               lend;
    logic               fend;

    always_comb
    begin
        irq_next = irq_reg;
        if (line_reg == cfg.irq_line)
        begin
            if (!irq_reg && cycle_reg == cfg.irq_first_cycle)
            begin
                irq_next = 1'b1;
            end
            else if (irq_reg && cycle_reg >= cfg.irq_last_cycle)
            begin
                irq_next = 1'b0;
            end
        end

        col_off   = cycle_reg - cfg.display_first_cycle;
        row_off   = line_reg - cfg.display_first_line;
        in_window = cycle_reg >= cfg.display_first_cycle
                    && line_reg >= cfg.display_first_line
                    && col_off < BEAM_W'(DISPLAY_COLS)
                    && row_off < BEAM_W'(DISPLAY_ROWS);

        cycle_inc = cycle_reg + 1'b1;
        line_inc  = line_reg + 1'b1;
        lend      = (&cycle_reg) || cycle_inc == cfg.line_cycles;
        fend      = (&line_reg) || line_inc == cfg.frame_lines;
        if (lend)
        begin
            cycle_next = '0;
            line_next  = fend ? '0 : line_inc;
        end
        else
        begin
            cycle_next = cycle_inc;
            line_next  = line_reg;
        end

        flash_inc = {1'b0, flash_cnt_reg} + 1'b1;
        if (flash_inc >= {1'b0, cfg.flash_period} || flash_inc[FLASH_W])
        begin
            flash_cnt_next = '0;
            flash_next     = !flash_reg;
        end
        else
        begin
            flash_cnt_next = flash_inc[FLASH_W-1:0];
            flash_next     = flash_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_reg     <= '0;
            line_reg      <= '0;
            irq_reg       <= 1'b0;
            flash_cnt_reg <= '0;
            flash_reg     <= 1'b0;
        end
        else if (tick)
        begin
            cycle_reg     <= cycle_next;
            line_reg      <= line_next;
            irq_reg       <= irq_next;
            flash_cnt_reg <= flash_cnt_next;
            flash_reg     <= flash_next;
        end
    end

    always_comb
    begin
        info.irq_level   = irq_next;
        info.pixel_valid = in_window;
        info.row         = in_window ? row_off[7:0] : 8'd0;
        info.col         = in_window ? col_off[4:0] : 5'd0;
        info.flash_phase = flash_reg;
        info.line_end    = lend;
        info.frame_end   = lend && fend;
    end

    // interleaved bitmap layout: third, pixel line, character row, column
    assign pixel_addr = {row_off[7:6], row_off[2:0], row_off[5:3], col_off[4:0]};
    assign attr_addr  = VRAM_AW'(ATTR_OFFSET) + VRAM_AW'({row_off[7:3], col_off[4:0]});
    assign irq_now    = irq_reg;

endmodule
